[rtl/core/pcxrle_pkg.sv]
package pcxrle_pkg;

   // Encoding constants of the PCX run-length scheme.
   localparam logic [5:0] RUN_MAX    = 6'd63;
   localparam logic [7:0] COUNT_BASE = 8'hC0;
   localparam logic [7:0] LONE_MARK  = 8'hC1;

   // Reset value of the line width register.
   localparam logic [9:0] LINE_WIDTH_RESET = 10'd512;

   // Command queue between the front and back parts.
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // One queued command: up to four encoded bytes caused by one pixel.
   typedef struct packed {
      logic [2:0]      nbytes;
      logic [3:0][7:0] bytes;
      logic            line_end;
   } cmd_type;

   // Status of the queue head as seen by the back part.
   typedef struct packed {
      logic valid;
   } qctl_type;

endpackage

[rtl/core/pcxrle_if.sv]
// Pixel input channel.
interface pcxrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// Encoded byte output channel.
interface pcxrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       line_done;

   modport source (output valid, output out_byte, output last, output line_done, input ready);
   modport sink   (input valid, input out_byte, input last, input line_done, output ready);
endinterface

// Line width register write channel.
interface pcxrle_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] line_width;

   modport source (output valid, output line_width, input ready);
   modport sink   (input valid, input line_width, output ready);
endinterface

[rtl/core/pcxrle_front.sv]
module pcxrle_front #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [9:0]          csr_line_width,
   input  logic                accept,
   input  logic [7:0]          pixel,
   output logic                push,
   output pcxrle_pkg::cmd_type cmd
);
   import pcxrle_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = (COL_W + 1 > 11) ? COL_W + 1 : 11;

   logic [9:0]       line_width_ff;
   logic [7:0]       held_ff, held_in;
   logic [5:0]       run_ff, run_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic [WW-1:0] eff_width;
   logic [WW-1:0] col_next;
   logic          extend;
   logic          line_end;
   logic [7:0]    new_held;
   logic [5:0]    new_run;
   logic [2:0]    k;

   // Width register; the user must write it only while the block is idle, as the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_valid) begin
         line_width_ff <= csr_line_width;
      end
   end

   // Effective width: zero acts as one, values above the maximum saturate.
   always_comb begin
      eff_width = WW'(line_width_ff);
      if (line_width_ff == 10'd0) begin
         eff_width = WW'(1);
      end else if (eff_width > WW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end
   end

   assign col_next = WW'(col_ff) + WW'(1);
   assign line_end = (col_next >= eff_width);
   assign extend   = (run_ff != 6'd0) && (pixel == held_ff) && (run_ff < RUN_MAX);
   assign new_held = extend ? held_ff : pixel;
   assign new_run  = extend ? run_ff + 6'd1 : 6'd1;

   // Classify the pixel and pack the bytes that flush the old run and, at line end, the new run.
   always_comb begin
      cmd.bytes    = '0;
      cmd.line_end = line_end;
      k            = 3'd0;
      if (!extend && run_ff != 6'd0) begin
         if (run_ff >= 6'd2) begin
            cmd.bytes[k[1:0]] = COUNT_BASE + {2'b00, run_ff};
            k = k + 3'd1;
         end else if (held_ff >= COUNT_BASE) begin
            cmd.bytes[k[1:0]] = LONE_MARK;
            k = k + 3'd1;
         end
         cmd.bytes[k[1:0]] = held_ff;
         k = k + 3'd1;
      end
      if (line_end) begin
         if (new_run >= 6'd2) begin
            cmd.bytes[k[1:0]] = COUNT_BASE + {2'b00, new_run};
            k = k + 3'd1;
         end else if (new_held >= COUNT_BASE) begin
            cmd.bytes[k[1:0]] = LONE_MARK;
            k = k + 3'd1;
         end
         cmd.bytes[k[1:0]] = new_held;
         k = k + 3'd1;
      end
      cmd.nbytes = k;
      push       = accept && (k != 3'd0);
   end

   // Next run and column state.
   always_comb begin
      held_in = new_held;
      run_in  = line_end ? 6'd0 : new_run;
      col_in  = line_end ? '0 : col_next[COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 8'd0;
         run_ff  <= 6'd0;
         col_ff  <= '0;
      end else if (accept) begin
         held_ff <= held_in;
         run_ff  <= run_in;
         col_ff  <= col_in;
      end
   end

endmodule

[rtl/core/pcxrle_queue.sv]
module pcxrle_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcxrle_pkg::cmd_type  push_cmd,
   output logic                 full,
   input  logic                 pop,
   output pcxrle_pkg::qctl_type head_ctl,
   output pcxrle_pkg::cmd_type  head_cmd
);
   import pcxrle_pkg::*;

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full           = (count_ff == QCNT_W'(QDEPTH));
   assign head_ctl.valid = (count_ff != '0);
   assign head_cmd       = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/pcxrle_back.sv]
module pcxrle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pcxrle_pkg::qctl_type head_ctl,
   input  pcxrle_pkg::cmd_type  head_cmd,
   output logic                 pop,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last,
   output logic                 rsp_line_done
);
   import pcxrle_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       done_ff;
   logic       load;
   logic       is_last;

   // A queued byte refills the output register when it is empty or taken.
   assign load    = head_ctl.valid && (!valid_ff || rsp_ready);
   assign is_last = ({1'b0, idx_ff} == head_cmd.nbytes - 3'd1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_cmd.bytes[idx_ff];
         last_ff <= is_last;
         done_ff <= is_last && head_cmd.line_end;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last      = last_ff;
   assign rsp_line_done = done_ff;

endmodule

[rtl/core/pcx_rle_line_encoder.sv]
// PCX run-length line encoder. Each req word carries one 8-bit pixel of a
// scanline; rsp words carry the encoded bytes, with last on the final byte a
// pixel causes and line_done on the final byte of a scanline. A pixel that only
// starts or extends a run produces no output word. Pixels are accepted one per
// cycle while the four-entry command queue has room; the output side delivers
// one byte per cycle while rsp ready is high, so the rate is set by the bytes
// a pixel causes: up to two to flush a run or a marked literal, and up to four
// on a line-end pixel that closes two runs. The line width register is written
// through the csr channel, which is always ready; write it only while the
// encoder is idle. MAX_WIDTH sets the largest usable line width.
module pcx_rle_line_encoder #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                clock,
   input  logic                reset,
   pcxrle_req_if.sink          req_chan,
   pcxrle_rsp_if.source        rsp_chan,
   pcxrle_csr_if.sink          csr_chan
);
   import pcxrle_pkg::*;

   logic     accept;
   logic     push;
   logic     full;
   logic     pop;
   cmd_type  push_cmd;
   cmd_type  head_cmd;
   qctl_type head_ctl;

   assign req_chan.ready = !full;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && !full;

   // Front: run tracking and command building.
   pcxrle_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_chan.valid),
      .csr_line_width (csr_chan.line_width),
      .accept         (accept),
      .pixel          (req_chan.pixel),
      .push           (push),
      .cmd            (push_cmd)
   );

   // Command queue.
   pcxrle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_ctl (head_ctl),
      .head_cmd (head_cmd)
   );

   // Back: byte serializer.
   pcxrle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_ctl      (head_ctl),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_out_byte  (rsp_chan.out_byte),
      .rsp_last      (rsp_chan.last),
      .rsp_line_done (rsp_chan.line_done)
   );

   // The end of a line always closes the byte group of its pixel.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.line_done |-> rsp_chan.last)
      else $error("line_done without last");

   // The front never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue overflow");

   // The back only pops a present entry.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_ctl.valid)
      else $error("command queue underflow");

   // A queued command always holds at least one byte.
   a_nonempty_cmd: assert property (@(posedge clock) disable iff (reset)
      head_ctl.valid |-> (head_cmd.nbytes != 3'd0))
      else $error("empty command in queue");

endmodule

[tb/sv/pcx_rle_line_encoder_tb.sv]
`timescale 1ns / 1ps

module pcx_rle_line_encoder_tb;
   import pcxrle_pkg::*;

   localparam int MAX_W = 512;
   // Cycles to let the encoder settle before a width write.
   localparam int SETTLE = 16;

   // One encoded output word as the encoder should deliver it.
   typedef struct {
      logic [7:0] code;
      logic       last;
      logic       line_done;
   } enc_word_type;

   // Tracks the run encoder state and the encoded words still owed by the DUT.
   class rle_scoreboard;
      bit [9:0]     width_reg;
      logic [7:0]   held_value;
      int unsigned  run_len;
      int unsigned  column;
      enc_word_type pending[$];
      enc_word_type fresh[$];
      int           errors;

      function new();
         width_reg  = LINE_WIDTH_RESET;
         held_value = '0;
         run_len    = 0;
         column     = 0;
         errors     = 0;
      endfunction

      function void set_width(bit [9:0] w);
         width_reg = w;
      endfunction

      function void put(logic [7:0] code, logic line_end);
         enc_word_type w;
         w.code      = code;
         w.last      = 1'b0;
         w.line_done = line_end;
         fresh.push_back(w);
      endfunction

      // Emit the held run: a count word for runs of two or more, the marker
      // for a lone value that would read as a count, then the value itself.
      function void flush_held(logic line_end);
         if (run_len == 0) return;
         if (run_len >= 2)
            put(8'(COUNT_BASE + run_len), 1'b0);
         else if (held_value >= COUNT_BASE)
            put(LONE_MARK, 1'b0);
         put(held_value, line_end);
         run_len = 0;
      endfunction

      // Work out the words caused by one accepted pixel.
      function void note_pixel(logic [7:0] px);
         int unsigned eff;
         fresh.delete();
         if (run_len != 0 && px == held_value && run_len < RUN_MAX) begin
            run_len++;
         end else begin
            flush_held(1'b0);
            held_value = px;
            run_len    = 1;
         end
         // A zero width acts as one; widths above the maximum saturate.
         eff = width_reg;
         if (eff == 0) eff = 1;
         if (eff > MAX_W) eff = MAX_W;
         if (column + 1 >= eff) begin
            flush_held(1'b1);
            column = 0;
         end else begin
            column++;
         end
         if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) pending.push_back(fresh[i]);
      endfunction

      function void report(string what, enc_word_type want, logic [7:0] code, logic last,
                           logic ld);
         errors++;
         if (errors <= 10) begin
            $write("%0t: %s: expected byte=%02h last=%0b line_done=%0b,",
                   $realtime, what, want.code, want.last, want.line_done);
            $display(" got byte=%02h last=%0b line_done=%0b", code, last, ld);
         end
      endfunction

      // Compare one accepted output word with the oldest expectation.
      function void check_word(logic [7:0] code, logic last, logic ld);
         enc_word_type want;
         if (pending.size() == 0) begin
            want = '{8'h00, 1'b0, 1'b0};
            report("unexpected word", want, code, last, ld);
            return;
         end
         want = pending.pop_front();
         if (code !== want.code || last !== want.last || ld !== want.line_done)
            report("word mismatch", want, code, last, ld);
      endfunction

      function void finish();
         if (pending.size() != 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: %0d expected words never arrived", $realtime, pending.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   recv_hold;

   pcxrle_req_if req_bus();
   pcxrle_rsp_if rsp_bus();
   pcxrle_csr_if csr_bus();

   rle_scoreboard board = new();

   // Hand-picked pixels for an eight-wide line: short runs, marked lone values,
   // a plain lone value, a lone marked value at line end, a full-line run and
   // a walking one.
   logic [7:0] directed_pixels [24] = '{
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hC0, 8'hBF, 8'hC1,
      8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
      8'h01, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02
   };

   pcx_rle_line_encoder #(
      .MAX_WIDTH (MAX_W)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Output side: random or held-off ready, check each accepted word.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (recv_hold > 0) begin
            rsp_bus.ready = 1'b0;
            recv_hold--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            board.check_word(rsp_bus.out_byte, rsp_bus.last, rsp_bus.line_done);
      end
   end

   // Offer one pixel, with random gaps, and note it once accepted.
   task automatic send_pixel(input logic [7:0] px);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.pixel = px;
      do @(posedge clock); while (!req_bus.ready);
      board.note_pixel(px);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Write the line width once the encoder has gone quiet.
   task automatic write_width(input bit [9:0] w);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_bus.valid      = 1'b1;
      csr_bus.line_width = w;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_width(w);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Send runs of random values and lengths; optionally open with a run long
   // enough to overflow the count, and optionally stop midway until the
   // output side has caught up.
   task automatic send_stream(input int count, input bit force_long, input int pause_at);
      int         sent;
      int         run_n;
      int         roll;
      logic [7:0] val;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(9))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            2, 3:    val = 8'($urandom_range(8'hC0, 8'hFF));
            default: val = 8'($urandom_range(255));
         endcase
         roll = $urandom_range(99);
         if (roll < 55)      run_n = 1;
         else if (roll < 85) run_n = $urandom_range(2, 4);
         else if (roll < 95) run_n = $urandom_range(5, 20);
         else                run_n = $urandom_range(21, 70);
         if (force_long && sent == 0) run_n = $urandom_range(64, 130);
         repeat (run_n) begin
            if (sent < count) begin
               if (sent == pause_at) begin
                  @(negedge clock);
                  req_bus.valid = 1'b0;
                  drain();
               end
               send_pixel(val);
               sent++;
            end
         end
      end
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Main sequence.
   initial begin : main_seq
      int waited;
      req_bus.valid      = 1'b0;
      req_bus.pixel      = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.line_width = '0;
      reset              = 1'b1;
      recv_hold          = 0;
      send_idle_pct      = 18;
      recv_idle_pct      = 73;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Busy sender, slow receiver.
      write_width(10'd8);
      foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
      @(negedge clock);
      req_bus.valid = 1'b0;
      write_width(10'd1023);
      // Short runs while the receiver holds off, so the queue fills up.
      recv_hold = 80;
      send_stream(60, 1'b0, -1);

      // Slow sender, eager receiver. The writes of widths 0 and 5 below land mid-line.
      send_idle_pct = 73;
      recv_idle_pct = 18;
      write_width(10'd0);
      send_stream(30, 1'b0, -1);
      write_width(10'd37);
      send_stream(60, 1'b0, 30);
      write_width(10'd5);
      send_stream(40, 1'b0, -1);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_width(LINE_WIDTH_RESET);
      send_stream(80, 1'b1, -1);
      write_width(10'd1);
      send_stream(25, 1'b0, -1);
      write_width(10'($urandom_range(3, 511)));
      send_stream(50, 1'b0, -1);

      // Let the last words come out, with a bound.
      waited = 0;
      while (board.pending.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      board.finish();
      if (board.errors == 0)
         $display("pcx_rle_line_encoder_tb passed");
      else
         $display("pcx_rle_line_encoder_tb failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("pcx_rle_line_encoder_tb failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_if.sv
rtl/core/pcxrle_front.sv
rtl/core/pcxrle_queue.sv
rtl/core/pcxrle_back.sv
rtl/core/pcx_rle_line_encoder.sv
tb/sv/pcx_rle_line_encoder_tb.sv
